/* hdl/yrpdm_pkg.sv */
// Shared types and constants for the yaw-rate PID drive mixer.
package yrpdm_pkg;

    // Field widths
    localparam int SPEED_W = 12;
    localparam int YAW_W   = 11;
    localparam int POWER_W = 8;
    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 15;
    localparam int ADDR_W  = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    // Register indexes
    localparam logic [ADDR_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [ADDR_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_INTEG_LIMIT = 3'd3;
    localparam logic [ADDR_W-1:0] REG_SPEED_GAIN  = 3'd4;
    localparam logic [ADDR_W-1:0] REG_ROT_GAIN    = 3'd5;

    // Register reset values
    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN   = 16'd102;
    localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN  = 16'd26;
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN  = 16'd26;
    localparam logic [LIMIT_W-1:0] RST_INTEG_LIMIT = 15'd1000;
    localparam logic [GAIN_W-1:0]  RST_SPEED_GAIN  = 16'd293;
    localparam logic [GAIN_W-1:0]  RST_ROT_GAIN    = 16'd358;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_ACC,
        S_MUL_R,
        S_MUL_S,
        S_SUM,
        S_SAT
    } t_state;

    // Operand pair for the shared multiplier
    typedef enum logic [2:0] {
        MUL_PROP,
        MUL_INTEG,
        MUL_DERIV,
        MUL_ROT,
        MUL_SPEED
    } t_mul_sel;

    typedef struct packed {
        logic     load;       // input beat accepted
        t_mul_sel mul_sel;
        logic     acc_init;   // acc = yaw*256 + product
        logic     acc_add;    // acc += product
        logic     rot_store;  // keep rotation product
        logic     mix_en;     // form fwd +/- rot
        logic     out_load;   // saturate into output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;       // output register can take a result
    } t_dp_stat;

endpackage

/* hdl/yaw_rate_pid_drive_mixer_unit.sv */
// Top level of the yaw-rate PID drive mixer.
//
// Use: one input beat per control tick on the s_axis channel carries the
// forward-speed target, the yaw-rate target and the measured gyro yaw rate.
// The block runs a PID on the yaw-rate error (integral clamped to
// +/- integ_limit, derivative = change of error), mixes in the speed
// feed-forward and returns one m_axis beat with right and left motor power,
// each truncated toward zero and saturated to +/-100.
// Timing: s_axis_tready is high only while the sequencer is idle. After an
// accepted beat the sequencer runs its states in turn and registers the result;
// the next beat is taken only once it is back in idle. All five products go
// through a single 33x17 multiplier, one after another.
// Stall: a pending result sits in the output register; a new beat is taken
// meanwhile, and only its final load waits until the receiver takes the old one.
// Reset (synchronous, active low): gains return to defaults, the error
// integral and previous error clear, and no result is pending.
// Config: write i_cfg_we/i_cfg_addr/i_cfg_wdata only while the block is idle.
module yaw_rate_pid_drive_mixer_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Config write port
    input  logic                                 i_cfg_we,
    input  logic [yrpdm_pkg::ADDR_W-1:0]         i_cfg_addr,
    input  logic [yrpdm_pkg::GAIN_W-1:0]         i_cfg_wdata,
    // Input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [11:0] speed_target, [22:12] yaw_target, [33:23] measured_yaw_rate, rest zero
    input  logic [yrpdm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [7:0] right_power, [15:8] left_power
    output logic [yrpdm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    yrpdm_pkg::t_dp_cmd  w_cmd;
    yrpdm_pkg::t_dp_stat w_stat;

    // Sequencer: at most one multiplier step per state
    yrpdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath: registers, PID state, multiplier, mixer, output beat
    yrpdm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

/* hdl/yrpdm_ctrl.sv */
// Sequencer for the yaw-rate PID drive mixer.
module yrpdm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  yrpdm_pkg::t_dp_stat i_stat,
    output yrpdm_pkg::t_dp_cmd  o_cmd
);

    yrpdm_pkg::t_state r_state;
    yrpdm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= yrpdm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            yrpdm_pkg::S_IDLE: begin
                if (i_s_tvalid) n_state = yrpdm_pkg::S_MUL_P;
            end
            yrpdm_pkg::S_MUL_P: n_state = yrpdm_pkg::S_MUL_I;
            yrpdm_pkg::S_MUL_I: n_state = yrpdm_pkg::S_MUL_D;
            yrpdm_pkg::S_MUL_D: n_state = yrpdm_pkg::S_ACC;
            yrpdm_pkg::S_ACC:   n_state = yrpdm_pkg::S_MUL_R;
            yrpdm_pkg::S_MUL_R: n_state = yrpdm_pkg::S_MUL_S;
            yrpdm_pkg::S_MUL_S: n_state = yrpdm_pkg::S_SUM;
            yrpdm_pkg::S_SUM:   n_state = yrpdm_pkg::S_SAT;
            yrpdm_pkg::S_SAT: begin
                if (i_stat.out_free) n_state = yrpdm_pkg::S_IDLE;
            end
            default: n_state = yrpdm_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_tready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.mul_sel  = yrpdm_pkg::MUL_PROP;
        o_cmd.acc_init = 1'b0;
        o_cmd.acc_add  = 1'b0;
        o_cmd.rot_store = 1'b0;
        o_cmd.mix_en   = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            yrpdm_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            yrpdm_pkg::S_MUL_P: o_cmd.mul_sel = yrpdm_pkg::MUL_PROP;
            yrpdm_pkg::S_MUL_I: begin
                o_cmd.mul_sel  = yrpdm_pkg::MUL_INTEG;
                o_cmd.acc_init = 1'b1;
            end
            yrpdm_pkg::S_MUL_D: begin
                o_cmd.mul_sel = yrpdm_pkg::MUL_DERIV;
                o_cmd.acc_add = 1'b1;
            end
            yrpdm_pkg::S_ACC:   o_cmd.acc_add = 1'b1;
            yrpdm_pkg::S_MUL_R: o_cmd.mul_sel = yrpdm_pkg::MUL_ROT;
            yrpdm_pkg::S_MUL_S: begin
                o_cmd.mul_sel   = yrpdm_pkg::MUL_SPEED;
                o_cmd.rot_store = 1'b1;
            end
            yrpdm_pkg::S_SUM:   o_cmd.mix_en = 1'b1;
            yrpdm_pkg::S_SAT:   o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == yrpdm_pkg::S_MUL_P)
        else $error("accept did not start the sequence");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded over a pending one");

endmodule

/* hdl/yrpdm_dp.sv */
// Datapath: config registers, PID state, shared multiplier, mixer and output register.
module yrpdm_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [yrpdm_pkg::ADDR_W-1:0]         i_cfg_addr,
    input  logic [yrpdm_pkg::GAIN_W-1:0]         i_cfg_wdata,
    input  logic [yrpdm_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  yrpdm_pkg::t_dp_cmd                   i_cmd,
    output yrpdm_pkg::t_dp_stat                  o_stat,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [yrpdm_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    // Config registers
    logic [15:0] r_prop_gain, r_integ_gain, r_deriv_gain, r_speed_gain, r_rot_gain;
    logic [14:0] r_integ_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= yrpdm_pkg::RST_PROP_GAIN;
            r_integ_gain  <= yrpdm_pkg::RST_INTEG_GAIN;
            r_deriv_gain  <= yrpdm_pkg::RST_DERIV_GAIN;
            r_integ_limit <= yrpdm_pkg::RST_INTEG_LIMIT;
            r_speed_gain  <= yrpdm_pkg::RST_SPEED_GAIN;
            r_rot_gain    <= yrpdm_pkg::RST_ROT_GAIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                yrpdm_pkg::REG_PROP_GAIN:   r_prop_gain   <= i_cfg_wdata;
                yrpdm_pkg::REG_INTEG_GAIN:  r_integ_gain  <= i_cfg_wdata;
                yrpdm_pkg::REG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_wdata;
                yrpdm_pkg::REG_INTEG_LIMIT: r_integ_limit <= i_cfg_wdata[14:0];
                yrpdm_pkg::REG_SPEED_GAIN:  r_speed_gain  <= i_cfg_wdata;
                yrpdm_pkg::REG_ROT_GAIN:    r_rot_gain    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input unpack and error terms
    logic [11:0] w_speed;
    logic [10:0] w_yaw, w_meas;
    logic [11:0] w_err;
    logic [12:0] w_diff;
    logic signed [16:0] w_sum_raw, w_lim;
    logic [15:0] w_sum_clamp;

    assign w_speed = i_s_tdata[11:0];
    assign w_yaw   = i_s_tdata[22:12];
    assign w_meas  = i_s_tdata[33:23];

    logic [15:0] r_error_sum;
    logic [11:0] r_last_error;

    assign w_err     = {w_yaw[10], w_yaw} - {w_meas[10], w_meas};
    assign w_diff    = {w_err[11], w_err} - {r_last_error[11], r_last_error};
    assign w_sum_raw = $signed({r_error_sum[15], r_error_sum})
                     + $signed({{5{w_err[11]}}, w_err});
    assign w_lim     = $signed({2'b00, r_integ_limit});

    always_comb begin
        if (w_sum_raw > w_lim) begin
            w_sum_clamp = w_lim[15:0];
        end else if (w_sum_raw < -w_lim) begin
            w_sum_clamp = 16'(-w_lim);
        end else begin
            w_sum_clamp = w_sum_raw[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum  <= '0;
            r_last_error <= '0;
        end else if (i_cmd.load) begin
            r_error_sum  <= w_sum_clamp;
            r_last_error <= w_err;
        end
    end

    // Operands held for the sequence
    logic [11:0] r_err, r_speed;
    logic [12:0] r_diff;
    logic [15:0] r_sum;
    logic [10:0] r_yaw;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err   <= w_err;
            r_diff  <= w_diff;
            r_sum   <= w_sum_clamp;
            r_yaw   <= w_yaw;
            r_speed <= w_speed;
        end
    end

    // Shared multiplier: 33-bit signed by unsigned gain
    logic signed [32:0] w_mul_a;
    logic signed [16:0] w_mul_b;
    logic signed [49:0] w_prod;
    logic signed [49:0] r_prod;
    logic signed [32:0] r_acc;

    always_comb begin
        case (i_cmd.mul_sel)
            yrpdm_pkg::MUL_PROP: begin
                w_mul_a = $signed({{21{r_err[11]}}, r_err});
                w_mul_b = $signed({1'b0, r_prop_gain});
            end
            yrpdm_pkg::MUL_INTEG: begin
                w_mul_a = $signed({{17{r_sum[15]}}, r_sum});
                w_mul_b = $signed({1'b0, r_integ_gain});
            end
            yrpdm_pkg::MUL_DERIV: begin
                w_mul_a = $signed({{20{r_diff[12]}}, r_diff});
                w_mul_b = $signed({1'b0, r_deriv_gain});
            end
            yrpdm_pkg::MUL_ROT: begin
                w_mul_a = r_acc;
                w_mul_b = $signed({1'b0, r_rot_gain});
            end
            yrpdm_pkg::MUL_SPEED: begin
                w_mul_a = $signed({{21{r_speed[11]}}, r_speed});
                w_mul_b = $signed({1'b0, r_speed_gain});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    // PID sum, seeded with yaw*256 so the acc ends as yaw*256 + u (Q.8)
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_init) begin
            r_acc <= $signed({{14{r_yaw[10]}}, r_yaw, 8'h00}) + r_prod[32:0];
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod[32:0];
        end
    end

    // Mixer in Q.16
    logic signed [48:0] r_rot;
    logic signed [49:0] w_fwd, w_rot_ext;
    logic signed [49:0] r_right_sum, r_left_sum;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rot_store) r_rot <= r_prod[48:0];
    end

    assign w_fwd     = $signed({r_prod[41:0], 8'h00});
    assign w_rot_ext = $signed({r_rot[48], r_rot});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix_en) begin
            r_right_sum <= w_fwd + w_rot_ext;
            r_left_sum  <= w_fwd - w_rot_ext;
        end
    end

    // Truncate toward zero, then saturate to +/-100
    function automatic logic [7:0] f_to_power(input logic signed [49:0] s);
        logic signed [33:0] q;
        q = s[49:16];
        if (s[49] && (s[15:0] != 16'h0000)) q = q + 34'sd1;
        if (q > 34'sd100) q = 34'sd100;
        else if (q < -34'sd100) q = -34'sd100;
        return q[7:0];
    endfunction

    // Output register
    logic       r_out_valid;
    logic [7:0] r_right, r_left;

    assign o_stat.out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_right <= f_to_power(r_right_sum);
            r_left  <= f_to_power(r_left_sum);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_left, r_right};

    a_sum_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> ($signed({r_error_sum[15], r_error_sum}) <= w_lim)
                    && ($signed({r_error_sum[15], r_error_sum}) >= -w_lim))
        else $error("error integral outside clamp");

    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed(r_right) <= 8'sd100) && ($signed(r_right) >= -8'sd100)
                     && ($signed(r_left) <= 8'sd100) && ($signed(r_left) >= -8'sd100))
        else $error("motor power outside +/-100");

endmodule
